// ===== hw/rtl/hsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_pkg: shared types and constants for the hex servo command decoder
// Character codes, history depth, servo count and the hex digit decode.
// ----------------------------------------------------------------------------
package hsc_pkg;

    // Number of servo channels; an index at or above this is dropped
    localparam int NUM_SERVOS = 8;

    // Depth of the received byte history
    localparam int HIST_DEPTH = 5;

    // Character codes
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_0       = 8'h30;
    localparam logic [7:0] CHAR_9       = 8'h39;
    localparam logic [7:0] CHAR_UC_A    = 8'h41;
    localparam logic [7:0] CHAR_UC_F    = 8'h46;
    localparam logic [7:0] CHAR_LC_A    = 8'h61;
    localparam logic [7:0] CHAR_LC_F    = 8'h66;
    localparam logic [3:0] DIGIT_TEN    = 4'hA;

    typedef logic [7:0] byte_t;

    // Entry 0 holds the oldest byte, entry HIST_DEPTH-1 the newest
    typedef byte_t [HIST_DEPTH-1:0] hist_t;

    // One servo update
    typedef struct packed {
        logic [3:0]  servo_index;
        logic [15:0] servo_position;
    } result_t;

    // Hex character to digit value; anything that is not hex reads as 0
    function automatic logic [3:0] hex_value(input byte_t ch);
        logic [7:0] diff;
        begin
            diff = 8'h00;
            if (ch >= CHAR_0 && ch <= CHAR_9)
            begin
                diff = ch - CHAR_0;
                hex_value = diff[3:0];
            end
            else if (ch >= CHAR_UC_A && ch <= CHAR_UC_F)
            begin
                diff = ch - CHAR_UC_A;
                hex_value = diff[3:0] + DIGIT_TEN;
            end
            else if (ch >= CHAR_LC_A && ch <= CHAR_LC_F)
            begin
                diff = ch - CHAR_LC_A;
                hex_value = diff[3:0] + DIGIT_TEN;
            end
            else
            begin
                hex_value = 4'h0;
            end
        end
    endfunction

endpackage

// ===== hw/rtl/hsc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_if: valid/ready channels of the hex servo command decoder
// Byte request channel in, servo update request channel out.
// ----------------------------------------------------------------------------
interface hsc_rx_if;
    logic             valid;
    logic             ready;
    hsc_pkg::byte_t   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hsc_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  servo_index;
    logic [15:0] servo_position;

    modport source (output valid, output servo_index, output servo_position, input ready);
    modport sink   (input valid, input servo_index, input servo_position, output ready);
endinterface

// ===== hw/rtl/hex_servo_command_decoder.sv =====
`timescale 1ns / 1ps
// Latency: a newline byte's servo update is valid the cycle after it is taken.
// Throughput: one byte per cycle; a byte is taken every cycle the result
// register is empty or being emptied, and a stalled update holds off input.
// Reset: asynchronous; clears the byte history to zero bytes and empties the
// result register.
// ----------------------------------------------------------------------------
// hex_servo_command_decoder: serial hex servo command decoder
// Keeps the last five received bytes and emits a servo update on newline.
// ----------------------------------------------------------------------------
module hex_servo_command_decoder (
    input  logic        clk,
    input  logic        rst_n,
    hsc_rx_if.sink      rx,
    hsc_cmd_if.source   cmd
);

    logic              space;
    logic              take;
    logic              cmd_hit;
    hsc_pkg::hist_t    history;
    hsc_pkg::result_t  decoded;

    // Input request handshake
    assign rx.ready = space;
    assign take     = rx.valid && space;

    hsc_history u_history (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (take),
        .new_byte (rx.rx_byte),
        .history  (history)
    );

    hsc_decode u_decode (
        .rx_byte (rx.rx_byte),
        .history (history),
        .cmd_hit (cmd_hit),
        .cmd     (decoded)
    );

    hsc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && cmd_hit),
        .load_data (decoded),
        .space     (space),
        .cmd       (cmd)
    );

`ifndef ASSERT_OFF
    // A new update appears only right after a newline was taken
    a_rise_after_newline: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd.valid) |-> $past(rx.valid && rx.ready &&
                                   rx.rx_byte == hsc_pkg::CHAR_NEWLINE))
        else $error("update without newline");

    // Every update addresses an existing servo
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid |-> ({1'b0, cmd.servo_index} < 5'(hsc_pkg::NUM_SERVOS)))
        else $error("servo index out of range");

    // A stalled update blocks further input
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && !cmd.ready) |-> !rx.ready)
        else $error("input taken while update stalled");
`endif

endmodule

// ===== hw/rtl/hsc_history.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_history: received byte history
// Shift register of the last bytes taken; every accepted byte shifts in.
// ----------------------------------------------------------------------------
module hsc_history (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  hsc_pkg::byte_t  new_byte,
    output hsc_pkg::hist_t  history
);

    hsc_pkg::hist_t hist_reg;
    hsc_pkg::hist_t hist_next;

    // Drop the oldest entry, append the new byte at the newest end
    always_comb
    begin
        hist_next = hist_reg;
        if (shift_en)
        begin
            for (int i = 0; i < hsc_pkg::HIST_DEPTH - 1; i++)
            begin
                hist_next[i] = hist_reg[i+1];
            end
            hist_next[hsc_pkg::HIST_DEPTH-1] = new_byte;
        end
    end

    // History reads as zero bytes until filled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
        end
    end

    assign history = hist_reg;

endmodule

// ===== hw/rtl/hsc_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_decode: command line decode
// On a newline, turns the five history bytes into index and position and
// flags whether the index addresses an existing servo.
// ----------------------------------------------------------------------------
module hsc_decode (
    input  hsc_pkg::byte_t   rx_byte,
    input  hsc_pkg::hist_t   history,
    output logic             cmd_hit,
    output hsc_pkg::result_t cmd
);

    logic [3:0] index_digit;
    logic [4:0] servo_limit;

    assign servo_limit = 5'(hsc_pkg::NUM_SERVOS);

    // Oldest byte is the index, the next four the position, MSB first
    assign index_digit = hsc_pkg::hex_value(history[0]);

    always_comb
    begin
        cmd.servo_index    = index_digit;
        cmd.servo_position = {hsc_pkg::hex_value(history[1]),
                              hsc_pkg::hex_value(history[2]),
                              hsc_pkg::hex_value(history[3]),
                              hsc_pkg::hex_value(history[4])};
    end

    // Update only on newline with an index below the servo count
    assign cmd_hit = (rx_byte == hsc_pkg::CHAR_NEWLINE) &&
                     ({1'b0, index_digit} < servo_limit);

endmodule

// ===== hw/rtl/hsc_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_out_stage: result register
// Holds one servo update request until the consumer takes it.
// ----------------------------------------------------------------------------
module hsc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  hsc_pkg::result_t  load_data,
    output logic              space,
    hsc_cmd_if.source         cmd
);

    logic              valid_reg;
    logic              valid_next;
    hsc_pkg::result_t  data_reg;

    // Room when empty or when the held request leaves this cycle
    assign space = !valid_reg || cmd.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (cmd.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign cmd.valid          = valid_reg;
    assign cmd.servo_index    = data_reg.servo_index;
    assign cmd.servo_position = data_reg.servo_position;

endmodule
